>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by gclp_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GCLP_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define GCLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/gclp_pkg.sv
// ----------------------------------------------------------------------------
// gclp_pkg
// Shared constants and types of the G-code line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package gclp_pkg;

  localparam int MAX_WORDS = 8;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int MAX_FRAC  = 9;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_G     = 8'd71;
  localparam logic [7:0] CH_M     = 8'd77;
  localparam logic [7:0] CH_X     = 8'd88;
  localparam logic [7:0] CH_Y     = 8'd89;
  localparam logic [7:0] CH_F     = 8'd70;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SYNTAX  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // one finished line handed from front to back
  typedef struct packed {
    logic                          err;
    logic [CNT_W-1:0]              count;
    logic [MAX_WORDS-1:0][7:0]     letter;
    logic [MAX_WORDS-1:0][31:0]    mant;
    logic [MAX_WORDS-1:0][3:0]     frac;
    logic [MAX_WORDS-1:0]          neg;
  } line_t;

  function automatic logic [29:0] pow10(input logic [3:0] e);
    logic [29:0] p;
    case (e)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/gclp_front.sv
// ----------------------------------------------------------------------------
// gclp_front
// Byte-level tokenizer: collects letter/number words of one line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gclp_front import gclp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] text_byte,
  input  logic       q_full,
  output logic       push,
  output line_t      push_line
);

  typedef enum logic [3:0] {
    PH_LETTER = 4'b0001,
    PH_START  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  phase_t                     phase, phase_next;
  logic [CNT_W-1:0]           count, count_next;
  logic [MAX_WORDS-1:0][7:0]  letter, letter_next;
  logic [MAX_WORDS-1:0][31:0] mant, mant_next;
  logic [MAX_WORDS-1:0][3:0]  frac, frac_next;
  logic [MAX_WORDS-1:0]       neg, neg_next;

  logic             acc, ending, blank, digit, clr;
  logic [7:0]       c, up;
  logic [IDX_W-1:0] w;
  logic [31:0]      mac;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign c        = text_byte;
  assign ending   = (c == CH_LF) || (c == CH_CR);
  assign blank    = (c == CH_SPACE) || (c == CH_TAB);
  assign digit    = (c >= 8'd48) && (c <= 8'd57);
  assign up       = (c >= 8'd97 && c <= 8'd122) ? c - 8'd32 : c;
  assign w        = (count == '0) ? '0 : IDX_W'(count - CNT_W'(1));
  assign mac      = (mant[w] << 3) + (mant[w] << 1) + {28'd0, c[3:0]};

  always_comb begin
    phase_next  = phase;
    count_next  = count;
    letter_next = letter;
    mant_next   = mant;
    frac_next   = frac;
    neg_next    = neg;
    push        = 1'b0;
    push_line   = '{err: 1'b0, count: count, letter: letter, mant: mant,
                    frac: frac, neg: neg};
    if (acc) begin
      case (phase)
        PH_ERROR: begin
          if (ending) begin
            push          = 1'b1;
            push_line.err = 1'b1;
          end
        end
        PH_LETTER: begin
          if (blank) begin
          end else if (ending) begin
            push = (count != '0);
          end else if (up >= 8'd65 && up <= 8'd90 && count < CNT_W'(MAX_WORDS)) begin
            letter_next[count[IDX_W-1:0]] = up;
            count_next = count + CNT_W'(1);
            phase_next = PH_START;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        default: begin
          if (phase == PH_START && c == CH_MINUS) begin
            neg_next[w] = 1'b1;
            phase_next  = PH_DIGITS;
          end else if (phase == PH_START && !digit) begin
            if (ending) begin
              push          = 1'b1;
              push_line.err = 1'b1;
            end else begin
              phase_next = PH_ERROR;
            end
          end else if (digit) begin
            phase_next = PH_DIGITS;
            if (frac[w] == 4'd0) begin
              mant_next[w] = mac;
            end else if (frac[w] < 4'(MAX_FRAC + 1)) begin
              mant_next[w] = mac;
              frac_next[w] = frac[w] + 4'd1;
            end
          end else if (blank) begin
            phase_next = PH_LETTER;
          end else if (ending) begin
            push = 1'b1;
          end else if (c == CH_POINT) begin
            frac_next[w] = 4'd1;
          end else begin
            phase_next = PH_ERROR;
          end
        end
      endcase
    end
  end

  assign clr = push;

  always_ff @(posedge clk) begin
    letter <= letter_next;
    if (rst || clr) begin
      phase <= PH_LETTER;
      count <= '0;
      mant  <= '0;
      frac  <= '0;
      neg   <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
      mant  <= mant_next;
      frac  <= frac_next;
      neg   <= neg_next;
    end
  end

endmodule

>>> hw/rtl/gclp_queue.sv
// ----------------------------------------------------------------------------
// gclp_queue
// Two-entry line queue between tokenizer and executor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gclp_queue import gclp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  line_t push_line,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output line_t head
);

  line_t       ent [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_line;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/gclp_back.sv
// ----------------------------------------------------------------------------
// gclp_back
// Line executor: scales X/Y/F words, decodes the command, holds targets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gclp_back import gclp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [30:0] cfg_data,
  input  logic        q_empty,
  input  line_t       head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  cmd_letter,
  output logic [31:0] cmd_number,
  output logic [31:0] target_x,
  output logic [31:0] target_y,
  output logic [31:0] feed,
  output logic        relative_mode
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WORD  = 6'b000010,
    S_PREP  = 6'b000100,
    S_DIV   = 6'b001000,
    S_APPLY = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] idx;
  logic [31:0]      prod, quo;
  logic [32:0]      rem;
  logic [3:0]       eadj;
  logic [29:0]      divisor;
  logic [4:0]       bitcnt;
  logic [31:0]      held_x, held_y, held_feed;
  logic             mode_rel;

  logic [IDX_W-1:0] wi;
  logic [7:0]       wl;
  logic [3:0]       e0, k, ew;
  logic [9:0]       mult;
  logic             is_xy, is_f, done_words;
  logic [32:0]      rem_sh;
  logic [31:0]      val, num;
  logic [1:0]       st_cmd;
  logic [29:0]      pe;
  logic             pop_set;

  assign wi         = idx[IDX_W-1:0];
  assign wl         = head.letter[wi];
  assign done_words = (idx >= head.count);
  assign is_xy      = (wl == CH_X) || (wl == CH_Y);
  assign is_f       = (wl == CH_F);
  assign pe         = pow10(eadj);

  // exponent = fraction digits, capped; X/Y cancel up to three against 1000
  always_comb begin
    e0 = (head.frac[wi] == 4'd0) ? 4'd0 : head.frac[wi] - 4'd1;
    if (e0 > 4'd9) e0 = 4'd9;
    k  = (is_xy) ? ((e0 > 4'd3) ? 4'd3 : e0) : 4'd0;
    ew = e0 - k;
    case (k)
      4'd0:    mult = is_xy ? 10'd1000 : 10'd1;
      4'd1:    mult = 10'd100;
      4'd2:    mult = 10'd10;
      default: mult = 10'd1;
    endcase
  end

  assign rem_sh = {rem[31:0], prod[31]};
  assign val    = head.neg[wi] ? 32'd0 - quo : quo;
  assign num    = head.mant[0];

  // pop is registered: the line is popped in the cycle after its result is decided
  assign pop_set = ((state == S_IDLE) && !q_empty && !pop && head.err) ||
                   ((state == S_WORD) && (done_words || idx >= CNT_W'(MAX_WORDS)));

  always_comb begin
    st_cmd = ST_OK;
    if (head.letter[0] == CH_G) begin
      if (num != 32'd28 && num != 32'd90 && num != 32'd91 && num != 32'd1)
        st_cmd = ST_UNKNOWN;
    end else if (head.letter[0] == CH_M) begin
      if (num != 32'd0 && num != 32'd112 && num != 32'd114 && num != 32'd119 &&
          num != 32'd202 && num != 32'd222)
        st_cmd = ST_UNKNOWN;
    end else begin
      st_cmd = ST_UNKNOWN;
    end
  end

  assign out_valid     = (state == S_OUT);
  assign target_x      = held_x;
  assign target_y      = held_y;
  assign feed          = held_feed;
  assign relative_mode = mode_rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held_x    <= '0;
      held_y    <= '0;
      held_feed <= '0;
      mode_rel  <= 1'b0;
      pop       <= 1'b0;
    end else begin
      pop <= pop_set;
      if (cfg_write) held_feed <= {1'b0, cfg_data};
      case (state)
        S_IDLE: begin
          if (!q_empty && !pop) begin
            if (head.err) begin
              status     <= ST_SYNTAX;
              cmd_letter <= '0;
              cmd_number <= '0;
              state      <= S_OUT;
            end else begin
              if (mode_rel) begin
                held_x <= '0;
                held_y <= '0;
              end
              idx   <= CNT_W'(1);
              state <= S_WORD;
            end
          end
        end
        S_WORD: begin
          if (done_words || idx >= CNT_W'(MAX_WORDS)) begin
            status     <= st_cmd;
            cmd_letter <= head.letter[0];
            cmd_number <= num;
            if (head.letter[0] == CH_G) begin
              if (num == 32'd28) begin
                held_x <= '0;
                held_y <= '0;
              end else if (num == 32'd90) begin
                mode_rel <= 1'b0;
              end else if (num == 32'd91) begin
                mode_rel <= 1'b1;
              end
            end
            state <= S_OUT;
          end else if (is_xy || is_f) begin
            prod  <= 32'(head.mant[wi] * mult);
            eadj  <= ew;
            state <= S_PREP;
          end else begin
            idx <= idx + CNT_W'(1);
          end
        end
        S_PREP: begin
          if (eadj == 4'd0) begin
            quo   <= prod;
            state <= S_APPLY;
          end else begin
            divisor <= pe;
            prod    <= prod + {3'd0, pe[29:1]};
            rem     <= '0;
            bitcnt  <= 5'd31;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle, MSB first
          if (rem_sh >= {3'd0, divisor}) begin
            rem <= rem_sh - {3'd0, divisor};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[30:0], 1'b0};
          end
          prod   <= {prod[30:0], 1'b0};
          bitcnt <= bitcnt - 5'd1;
          if (bitcnt == 5'd0) state <= S_APPLY;
        end
        S_APPLY: begin
          if (wl == CH_X)      held_x    <= val;
          else if (wl == CH_Y) held_y    <= val;
          else                 held_feed <= val;
          idx   <= idx + CNT_W'(1);
          state <= S_WORD;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/gcode_line_parser.sv
// ----------------------------------------------------------------------------
// gcode_line_parser
// G-code line parser: byte tokenizer, line queue and line executor.
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// in      | in_valid/in_ready, text_byte     | byte stream in
// out     | out_valid/out_ready, result regs | one result per line
// cfg     | cfg_valid/cfg_ready, cfg_data    | initial feed write
//
// A byte is taken whenever the two-entry line queue has room.
// Line execution walks the words after the first in order: a word that is
// not X/Y/F is skipped, an X/Y/F word is scaled and applied, through the
// bit-serial divider when it keeps fraction digits after scaling; the result
// is then held until out_ready. A syntax-error line goes straight to the result.
// Reset is synchronous; no clearing pass. Output stalls only hold the
// executor; the tokenizer keeps going until the queue fills.
`timescale 1ns / 1ps
module gcode_line_parser import gclp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  cmd_letter,
  output logic [31:0] cmd_number,
  output logic [31:0] target_x,
  output logic [31:0] target_y,
  output logic [31:0] feed,
  output logic        relative_mode
);

  logic  q_full, q_empty, push, pop;
  line_t push_line, head;

  assign cfg_ready = 1'b1;

  gclp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .text_byte,
    .q_full, .push, .push_line
  );

  gclp_queue u_queue (
    .clk, .rst, .push, .push_line, .full(q_full),
    .pop, .empty(q_empty), .head
  );

  gclp_back u_back (
    .clk, .rst, .cfg_write(cfg_valid && cfg_ready), .cfg_data,
    .q_empty, .head, .pop, .out_valid, .out_ready,
    .status, .cmd_letter, .cmd_number, .target_x, .target_y, .feed,
    .relative_mode
  );

endmodule

>>> hw/rtl/gclp_checker.sv
// ----------------------------------------------------------------------------
// gclp_checker
// Port-level checks of the G-code line parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gclp_checker import gclp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  cmd_letter,
  input logic [31:0] cmd_number
);

  `GCLP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `GCLP_ASSERT(a_status_range, clk, rst, out_valid, status != 2'd3)
  `GCLP_ASSERT(a_syntax_zero, clk, rst, out_valid && status == ST_SYNTAX, cmd_letter == 8'd0 && cmd_number == 32'd0)
  `GCLP_ASSERT(a_ok_letter, clk, rst, out_valid && status == ST_OK, cmd_letter == CH_G || cmd_letter == CH_M)

endmodule

bind gcode_line_parser gclp_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .status, .cmd_letter, .cmd_number
);

>>> test/gcode_line_checker.sv
// ----------------------------------------------------------------------------
// gcode_line_checker
// Watches the byte, result and feed-write channels of the G-code line
// parser, predicts each line result from the byte stream and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module gcode_line_checker import gclp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [30:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [7:0]  cmd_letter,
  input  logic [31:0] cmd_number,
  input  logic [31:0] target_x,
  input  logic [31:0] target_y,
  input  logic [31:0] feed,
  input  logic        relative_mode,
  output int          mismatches,
  output int          lines_due,
  output int          lines_checked
);

  typedef enum logic [1:0] {EXPECT_LETTER, EXPECT_NUMBER, IN_NUMBER, SKIP_TO_EOL} phase_e;

  localparam logic [31:0] G_LINEAR = 32'd1;
  localparam logic [31:0] G_HOME   = 32'd28;
  localparam logic [31:0] G_ABS    = 32'd90;
  localparam logic [31:0] G_REL    = 32'd91;
  localparam logic [31:0] M_STOP   = 32'd0;
  localparam logic [31:0] M_ESTOP  = 32'd112;
  localparam logic [31:0] M_POS    = 32'd114;
  localparam logic [31:0] M_ENDST  = 32'd119;
  localparam logic [31:0] M_202    = 32'd202;
  localparam logic [31:0] M_222    = 32'd222;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  letter;
    logic [31:0] number;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] feed;
    logic        rel;
  } line_result_t;

  line_result_t expected_lines[$];

  phase_e      phase;
  int          n_words;
  logic [7:0]  w_letter[MAX_WORDS];
  logic [31:0] w_mant[MAX_WORDS];
  logic [3:0]  w_frac[MAX_WORDS];
  logic        w_neg[MAX_WORDS];
  logic        rel_mode;
  logic [31:0] pos_x, pos_y, cur_feed;

  assign lines_due = expected_lines.size();

  task clear_words();
    for (int i = 0; i < MAX_WORDS; i++) begin
      w_mant[i] = '0;
      w_frac[i] = '0;
      w_neg[i] = 1'b0;
    end
    n_words = 0;
    phase = EXPECT_LETTER;
  endtask

  function logic [31:0] scaled(int i, logic [31:0] mult);
    int e;
    logic [31:0] m, p;
    e = w_frac[i];
    if (e > 0) e--;
    if (e > 9) e = 9;
    m = w_mant[i];
    while (e > 0 && mult % 10 == 0) begin
      mult = mult / 10;
      e--;
    end
    m = m * mult;
    if (e > 0) begin
      p = 1;
      repeat (e) p = p * 10;
      m = (m + p / 2) / p;
    end
    return w_neg[i] ? -m : m;
  endfunction

  task push_result(logic [1:0] st, logic [7:0] letter, logic [31:0] number);
    line_result_t r;
    r = '{st, letter, number, pos_x, pos_y, cur_feed, rel_mode};
    expected_lines.push_back(r);
    clear_words();
  endtask

  task run_line();
    logic [1:0] st;
    logic [31:0] num;
    st = ST_OK;
    num = w_mant[0];
    if (rel_mode) begin
      pos_x = '0;
      pos_y = '0;
    end
    for (int i = 1; i < n_words && i < MAX_WORDS; i++) begin
      if (w_letter[i] == CH_X) pos_x = scaled(i, 32'd1000);
      else if (w_letter[i] == CH_Y) pos_y = scaled(i, 32'd1000);
      else if (w_letter[i] == CH_F) cur_feed = scaled(i, 32'd1);
    end
    if (w_letter[0] == CH_G) begin
      if (num == G_HOME) begin
        pos_x = '0;
        pos_y = '0;
      end else if (num == G_ABS) rel_mode = 1'b0;
      else if (num == G_REL) rel_mode = 1'b1;
      else if (num != G_LINEAR) st = ST_UNKNOWN;
    end else if (w_letter[0] == CH_M) begin
      if (!(num inside {M_STOP, M_ESTOP, M_POS, M_ENDST, M_202, M_222})) st = ST_UNKNOWN;
    end else begin
      st = ST_UNKNOWN;
    end
    push_result(st, w_letter[0], num);
  endtask

  task take_byte(logic [7:0] ch);
    logic eol, blank, digit;
    int w;
    eol = (ch == CH_LF || ch == CH_CR);
    blank = (ch == CH_SPACE || ch == CH_TAB);
    digit = (ch >= "0" && ch <= "9");
    w = (n_words > 0) ? n_words - 1 : 0;
    if (w > MAX_WORDS - 1) w = MAX_WORDS - 1;
    case (phase)
      SKIP_TO_EOL: begin
        if (eol) push_result(ST_SYNTAX, 8'd0, 32'd0);
      end
      EXPECT_LETTER: begin
        if (eol) begin
          if (n_words > 0) run_line();
        end else if (!blank) begin
          if (ch >= "a" && ch <= "z") ch = ch - 8'd32;
          if (ch >= "A" && ch <= "Z" && n_words < MAX_WORDS) begin
            w_letter[n_words] = ch;
            n_words++;
            phase = EXPECT_NUMBER;
          end else begin
            phase = SKIP_TO_EOL;
          end
        end
      end
      default: begin
        if (phase == EXPECT_NUMBER && !digit) begin
          if (ch == CH_MINUS) begin
            w_neg[w] = 1'b1;
            phase = IN_NUMBER;
          end else if (eol) push_result(ST_SYNTAX, 8'd0, 32'd0);
          else phase = SKIP_TO_EOL;
        end else begin
          phase = IN_NUMBER;
          if (digit) begin
            if (w_frac[w] == 0) begin
              w_mant[w] = w_mant[w] * 10 + (ch - "0");
            end else if (w_frac[w] < MAX_FRAC + 1) begin
              w_mant[w] = w_mant[w] * 10 + (ch - "0");
              w_frac[w]++;
            end
          end else if (blank) phase = EXPECT_LETTER;
          else if (eol) run_line();
          else if (ch == CH_POINT) w_frac[w] = 4'd1;
          else phase = SKIP_TO_EOL;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    line_result_t exp_r;
    if (rst) begin
      clear_words();
      expected_lines.delete();
      rel_mode = 1'b0;
      pos_x = '0;
      pos_y = '0;
      cur_feed = '0;
      mismatches <= 0;
      lines_checked <= 0;
    end else begin
      // result first: it always belongs to bytes taken on earlier edges
      if (out_valid && out_ready) begin
        lines_checked <= lines_checked + 1;
        if (expected_lines.size() == 0) begin
          if (mismatches < 10) $display("%0t: result with no line pending", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          exp_r = expected_lines.pop_front();
          if (exp_r.status !== status || exp_r.letter !== cmd_letter ||
              exp_r.number !== cmd_number || exp_r.x !== target_x ||
              exp_r.y !== target_y || exp_r.feed !== feed || exp_r.rel !== relative_mode) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp st=%0d cmd=%0d/%0d x=%0d y=%0d f=%0d rel=%0d, got st=%0d cmd=%0d/%0d x=%0d y=%0d f=%0d rel=%0d",
                       $realtime, exp_r.status, exp_r.letter, exp_r.number, $signed(exp_r.x),
                       $signed(exp_r.y), $signed(exp_r.feed), exp_r.rel, status, cmd_letter,
                       cmd_number, $signed(target_x), $signed(target_y), $signed(feed),
                       relative_mode);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) cur_feed = {1'b0, cfg_data};
      if (in_valid && in_ready) take_byte(text_byte);
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the G-code line parser: directed lines for each
// command and syntax corner, then random well-formed and broken lines under
// three handshake idling mixes, with feed writes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import gclp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  text_byte = 8'd0;
  logic        cfg_valid = 1'b0;
  logic [30:0] cfg_data = '0;
  logic        out_ready = 1'b0;
  logic        in_ready, cfg_ready, out_valid, relative_mode;
  logic [1:0]  status;
  logic [7:0]  cmd_letter;
  logic [31:0] cmd_number, target_x, target_y, feed;
  int          mismatches, lines_due, lines_checked;
  int          idle_in = 21, idle_out = 79;
  int          bytes_sent = 0;
  logic [7:0]  line_buf[$];

  gcode_line_parser uut (.*);

  gcode_line_checker checker_i (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_out);

  task send_byte(logic [7:0] b);
    if ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_in);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task flush_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task put_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // hold off until every pending line result is out, then let the executor settle
  task drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lines_due != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task write_feed(logic [30:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task put_blanks();
    repeat ($urandom_range(1, 2)) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  task put_value();
    if ($urandom_range(3) == 0) line_buf.push_back(CH_MINUS);
    repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(9)) + "0");
    if ($urandom_range(1)) begin
      line_buf.push_back(CH_POINT);
      repeat ($urandom_range(0, 11)) line_buf.push_back(8'($urandom_range(9)) + "0");
      if ($urandom_range(15) == 0) put_str(".5");
    end
  endtask

  task random_line();
    int pick, n_extra;
    logic [7:0] letters[4];
    letters = '{CH_X, CH_Y, CH_F, CH_G};
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 10)) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        line_buf.push_back($urandom_range(3) ? CH_G : "g");
        case ($urandom_range(6))
          0: put_str("0");
          1, 2: put_str("1");
          3: put_str("28");
          4: put_str("90");
          5: put_str("91");
          default: put_str($sformatf("%0d", $urandom_range(300)));
        endcase
      end else if (pick < 85) begin
        line_buf.push_back($urandom_range(3) ? CH_M : "m");
        case ($urandom_range(6))
          0: put_str("0");
          1: put_str("112");
          2: put_str("114");
          3: put_str("119");
          4: put_str("202");
          5: put_str("222");
          default: put_str($sformatf("%0d", $urandom_range(300)));
        endcase
      end else begin
        line_buf.push_back(8'($urandom_range(25)) + ($urandom_range(1) ? "A" : "a"));
        put_str($sformatf("%0d", $urandom_range(999)));
      end
      n_extra = ($urandom_range(19) == 0) ? 8 : $urandom_range(0, 4);
      repeat (n_extra) begin
        put_blanks();
        line_buf.push_back($urandom_range(9) ? letters[$urandom_range(2)]
                                             : 8'($urandom_range(25)) + "A");
        put_value();
      end
      if ($urandom_range(7) == 0) put_blanks();
      if ($urandom_range(9) == 0 && line_buf.size() > 1)
        line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    end
    case ($urandom_range(3))
      0: put_str("\r\n");
      1: line_buf.push_back(CH_CR);
      default: line_buf.push_back(CH_LF);
    endcase
    flush_line();
  endtask

  task random_phase(int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) random_line();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_feed(31'h7FFF_FFFF);

    put_str("G1 X10 Y-2.5\n");
    put_str("g28\n");
    put_str("G91\tx1.0005 Y-0.0004 \n");
    put_str("G90\r\n\n");
    put_str("M0\nM112\nM114\nM119\nM202\nM222\nM5\nT3\nG2\n");
    put_str("G1 X#5\n");
    line_buf.push_back(8'hFF);
    put_str("\nG1 X5\x00\nG1 X\nG\rG1 X-\r");
    put_str("G1 X1 Y1 F1 X2 Y2 F2 X3 Y3\n");
    put_str("G1 X1.2.5 Y0.1234567891234\n");
    put_str("G1 X99999999999 F-4294967296\nG4294967297\n");
    flush_line();

    drain();
    random_phase(500);
    idle_in = 79;
    idle_out = 21;
    write_feed(31'd0);
    random_phase(500);
    idle_in = 0;
    idle_out = 0;
    write_feed(31'($urandom()));
    random_phase(500);
    drain();

    $display("Sent %0d bytes over three handshake mixes; %0d line results checked.",
             bytes_sent, lines_checked);
    if (mismatches == 0 && lines_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/gclp_pkg.sv
hw/rtl/gclp_front.sv
hw/rtl/gclp_queue.sv
hw/rtl/gclp_back.sv
hw/rtl/gcode_line_parser.sv
hw/rtl/gclp_checker.sv
test/gcode_line_checker.sv
test/tb_top.sv
